FILE: sv/slcfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types, constants and the CRC step of the sync/length/CRC frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

	// Width of the running frame check.
	localparam int CRC_WIDTH = 16;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SYNC_FIRST    = 3'd0;
	localparam logic [2:0] CFG_SYNC_SECOND   = 3'd1;
	localparam logic [2:0] CFG_CRC_SEED      = 3'd2;
	localparam logic [2:0] CFG_CRC_GENERATOR = 3'd3;
	localparam logic [2:0] CFG_MAX_LENGTH    = 3'd4;

	// Configuration reset values.
	localparam logic [7:0]           SYNC_FIRST_RST    = 8'hAA;
	localparam logic [7:0]           SYNC_SECOND_RST   = 8'h55;
	localparam logic [CRC_WIDTH-1:0] CRC_SEED_RST      = 16'hFFFF;
	localparam logic [CRC_WIDTH-1:0] CRC_GENERATOR_RST = 16'h1021;
	localparam logic [15:0]          MAX_LENGTH_RST    = 16'd256;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LENHI = 3'd2,
		PH_LENLO = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRCHI = 3'd5,
		PH_CRCLO = 3'd6
	} phase_t;

	// Operations handed from the front to the back.
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_START  = 3'd1,
		OP_CRC    = 3'd2,
		OP_BADLEN = 3'd3,
		OP_DATA   = 3'd4,
		OP_CHKHI  = 3'd5,
		OP_CHKLO  = 3'd6
	} op_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_BADLEN   = 2'd3
	} kind_t;

	// Live configuration.
	typedef struct packed {
		logic [7:0]           sync_first;
		logic [7:0]           sync_second;
		logic [CRC_WIDTH-1:0] crc_seed;
		logic [CRC_WIDTH-1:0] crc_generator;
		logic [15:0]          max_length;
	} cfg_t;

	// One classified item in the queue.
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [15:0] index;
		logic [15:0] len;
	} entry_t;

	// One byte of an MSB-first CRC, eight shift steps unrolled.
	function automatic logic [CRC_WIDTH-1:0] crc_byte(
		input logic [CRC_WIDTH-1:0] crc_in,
		input logic [7:0]           data,
		input logic [CRC_WIDTH-1:0] gen
	);
		logic [CRC_WIDTH-1:0] c;
		c = crc_in ^ {data, {(CRC_WIDTH-8){1'b0}}};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_WIDTH-1]) begin
				c = {c[CRC_WIDTH-2:0], 1'b0} ^ gen;
			end else begin
				c = {c[CRC_WIDTH-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// True for operations that produce a result item.
	function automatic logic op_has_result(input op_t op);
		return (op == OP_BADLEN) || (op == OP_DATA) || (op == OP_CHKLO);
	endfunction

endpackage
`default_nettype wire

FILE: sv/sync_length_crc_frame_parser.sv
// Path: an accepted byte's result item passes through the queue, then the result register.
// Throughput: one byte per cycle while the queue is not full; the 8-bit unrolled CRC step in the back sets the cycle.
// A queue of QUEUE_DEPTH items lets the front keep accepting while a result is stalled.
// Reset (arst_n low, asynchronous) returns the parser to waiting for the first sync byte,
// empties the queue and the result register, and loads the register defaults.
// No memory clearing pass follows reset; bytes are accepted as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_crc_frame_parser
// Deframes sync, length, payload and CRC-16 bytes into payload and verdict
// items, with a classifying front, a queue and an executing back.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_parser #(
	parameter int QUEUE_DEPTH = slcfp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic [15:0] frame_length,
	output logic        last
);

	slcfp_pkg::cfg_t   cfg_q;
	slcfp_pkg::entry_t push_entry;
	slcfp_pkg::entry_t head_entry;
	logic              q_full;
	logic              q_push;
	logic              head_valid;
	logic              q_pop;

	// Configuration registers; writes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first    <= slcfp_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second   <= slcfp_pkg::SYNC_SECOND_RST;
			cfg_q.crc_seed      <= slcfp_pkg::CRC_SEED_RST;
			cfg_q.crc_generator <= slcfp_pkg::CRC_GENERATOR_RST;
			cfg_q.max_length    <= slcfp_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slcfp_pkg::CFG_SYNC_FIRST:    cfg_q.sync_first    <= cfg_data[7:0];
				slcfp_pkg::CFG_SYNC_SECOND:   cfg_q.sync_second   <= cfg_data[7:0];
				slcfp_pkg::CFG_CRC_SEED:      cfg_q.crc_seed      <= cfg_data;
				slcfp_pkg::CFG_CRC_GENERATOR: cfg_q.crc_generator <= cfg_data;
				slcfp_pkg::CFG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accepts and classifies bytes.
	slcfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// Queue between front and back.
	slcfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop)
	);

	// Back: CRC and result generation.
	slcfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length),
		.last         (last)
	);

endmodule
`default_nettype wire

FILE: sv/slcfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_front
// Accepts received bytes, tracks the frame phase, length and payload index,
// and classifies each byte into an operation for the back.
// ----------------------------------------------------------------------------
module slcfp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire slcfp_pkg::cfg_t cfg,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           rx_byte,
	input  wire                  q_full,
	output logic                 q_push,
	output slcfp_pkg::entry_t    q_entry
);

	slcfp_pkg::phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [15:0] len_full;
	logic [15:0] count_inc;
	logic        len_bad;
	logic        accept;
	slcfp_pkg::op_t op;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign len_full  = {len_q[15:8], rx_byte};
	assign count_inc = count_q + 16'd1;
	assign len_bad   = (len_full == 16'd0) || (len_full > cfg.max_length);

	// Next phase, length and payload count.
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		case (phase_q)
			slcfp_pkg::PH_SYNC2: begin
				if (rx_byte == cfg.sync_second) begin
					phase_d = slcfp_pkg::PH_LENHI;
					len_d   = '0;
					count_d = '0;
				end else if (rx_byte != cfg.sync_first) begin
					phase_d = slcfp_pkg::PH_SYNC1;
					len_d   = '0;
					count_d = '0;
				end
			end
			slcfp_pkg::PH_LENHI: begin
				phase_d = slcfp_pkg::PH_LENLO;
				len_d   = {rx_byte, 8'd0};
			end
			slcfp_pkg::PH_LENLO: begin
				count_d = '0;
				if (len_bad) begin
					phase_d = slcfp_pkg::PH_SYNC1;
					len_d   = '0;
				end else begin
					phase_d = slcfp_pkg::PH_DATA;
					len_d   = len_full;
				end
			end
			slcfp_pkg::PH_DATA: begin
				count_d = count_inc;
				if (count_inc >= len_q) begin
					phase_d = slcfp_pkg::PH_CRCHI;
				end
			end
			slcfp_pkg::PH_CRCHI: begin
				phase_d = slcfp_pkg::PH_CRCLO;
			end
			slcfp_pkg::PH_CRCLO: begin
				phase_d = slcfp_pkg::PH_SYNC1;
				len_d   = '0;
				count_d = '0;
			end
			default: begin
				if (rx_byte == cfg.sync_first) begin
					phase_d = slcfp_pkg::PH_SYNC2;
				end else begin
					phase_d = slcfp_pkg::PH_SYNC1;
				end
			end
		endcase
	end

	// Operation for the back.
	always_comb begin
		op = slcfp_pkg::OP_NONE;
		case (phase_q)
			slcfp_pkg::PH_SYNC2: begin
				if (rx_byte == cfg.sync_second) begin
					op = slcfp_pkg::OP_CRC;
				end else if (rx_byte == cfg.sync_first) begin
					op = slcfp_pkg::OP_START;
				end
			end
			slcfp_pkg::PH_LENHI: op = slcfp_pkg::OP_CRC;
			slcfp_pkg::PH_LENLO: begin
				op = len_bad ? slcfp_pkg::OP_BADLEN : slcfp_pkg::OP_CRC;
			end
			slcfp_pkg::PH_DATA:  op = slcfp_pkg::OP_DATA;
			slcfp_pkg::PH_CRCHI: op = slcfp_pkg::OP_CHKHI;
			slcfp_pkg::PH_CRCLO: op = slcfp_pkg::OP_CHKLO;
			default: begin
				if (rx_byte == cfg.sync_first) begin
					op = slcfp_pkg::OP_START;
				end
			end
		endcase
	end

	assign q_push        = accept && (op != slcfp_pkg::OP_NONE);
	assign q_entry.op    = op;
	assign q_entry.data  = rx_byte;
	assign q_entry.index = count_q;
	assign q_entry.len   = (phase_q == slcfp_pkg::PH_LENLO) ? len_full : len_q;

	// Parser state registers advance on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slcfp_pkg::PH_SYNC1;
			len_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
		end
	end

`ifndef ASSERT_OFF
	// The payload index stays below the declared length throughout the payload.
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slcfp_pkg::PH_DATA) |-> (count_q < len_q))
		else $error("payload index reached declared length in payload phase");
`endif

endmodule
`default_nettype wire

FILE: sv/slcfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module slcfp_queue #(
	parameter int DEPTH = slcfp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  wire slcfp_pkg::entry_t push_entry,
	output logic                   full,
	output logic                   head_valid,
	output slcfp_pkg::entry_t      head_entry,
	input  wire                    pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	slcfp_pkg::entry_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	// The fill count never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: sv/slcfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_back
// Executes queued operations: keeps the running CRC and the received check
// high byte, and drives the registered result channel.
// ----------------------------------------------------------------------------
module slcfp_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire slcfp_pkg::cfg_t   cfg,
	input  wire                    head_valid,
	input  wire slcfp_pkg::entry_t head_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [1:0]             kind,
	output logic [7:0]             payload_byte,
	output logic [15:0]            byte_index,
	output logic [15:0]            frame_length,
	output logic                   last
);

	logic [slcfp_pkg::CRC_WIDTH-1:0] crc_q;
	logic [slcfp_pkg::CRC_WIDTH-1:0] crc_base;
	logic [slcfp_pkg::CRC_WIDTH-1:0] crc_next;
	logic [7:0]                      chk_hi_q;
	logic                            out_valid_q;
	slcfp_pkg::kind_t                kind_q;
	logic [7:0]                      payload_byte_q;
	logic [15:0]                     byte_index_q;
	logic [15:0]                     frame_length_q;
	logic                            last_q;
	logic                            has_result;
	logic                            out_free;
	logic                            crc_match;

	assign has_result = slcfp_pkg::op_has_result(head_entry.op);
	assign out_free   = !out_valid_q || out_ready;
	assign pop        = head_valid && (!has_result || out_free);

	// One CRC byte step, restarting from the seed on a frame start.
	assign crc_base  = (head_entry.op == slcfp_pkg::OP_START) ? cfg.crc_seed : crc_q;
	assign crc_next  = slcfp_pkg::crc_byte(crc_base, head_entry.data, cfg.crc_generator);
	assign crc_match = ({chk_hi_q, head_entry.data} == crc_q);

	// Running check and stored check high byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= slcfp_pkg::CRC_SEED_RST;
			chk_hi_q <= '0;
		end else if (pop) begin
			case (head_entry.op)
				slcfp_pkg::OP_START,
				slcfp_pkg::OP_CRC,
				slcfp_pkg::OP_DATA:  crc_q <= crc_next;
				slcfp_pkg::OP_CHKHI: chk_hi_q <= head_entry.data;
				default: ;
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && has_result) begin
			frame_length_q <= head_entry.len;
			case (head_entry.op)
				slcfp_pkg::OP_DATA: begin
					kind_q         <= slcfp_pkg::KIND_PAYLOAD;
					payload_byte_q <= head_entry.data;
					byte_index_q   <= head_entry.index;
					last_q         <= 1'b0;
				end
				slcfp_pkg::OP_CHKLO: begin
					kind_q         <= crc_match ? slcfp_pkg::KIND_GOOD
					                            : slcfp_pkg::KIND_MISMATCH;
					payload_byte_q <= '0;
					byte_index_q   <= '0;
					last_q         <= 1'b1;
				end
				default: begin
					kind_q         <= slcfp_pkg::KIND_BADLEN;
					payload_byte_q <= '0;
					byte_index_q   <= '0;
					last_q         <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_byte_q;
	assign byte_index   = byte_index_q;
	assign frame_length = frame_length_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	// A result never overwrites one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(pop && has_result))
		else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire
